>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

// implication checked in the same cycle
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

`endif

>>> rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// types and constants of the sieve prime table and primality test block
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

	localparam int SIEVE_SIZE  = 65536;
	localparam int PRIME_DEPTH = 8192;
	localparam int MAP_AW      = 16;
	localparam int TBL_AW      = 13;
	localparam int LIMIT_W     = 17;
	localparam int COUNT_W     = 14;
	localparam int NUM_W       = 32;
	localparam int PRIME_W     = 16;
	localparam int ROUND_MAX   = 256;

	localparam logic FUNC_BUILD = 1'b0;
	localparam logic FUNC_TEST  = 1'b1;

	localparam logic [2:0] ADDR_SIEVE_LIMIT = 3'd0;

	typedef struct packed {
		logic             func;
		logic [NUM_W-1:0] number;
	} spt_in_t;

	typedef struct packed {
		logic               is_prime;
		logic               list_short;
		logic [COUNT_W-1:0] prime_count;
	} spt_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED0,
		ST_SEED1,
		ST_ROUND_MUL,
		ST_ROUND_CHK,
		ST_LOAD_P,
		ST_LOAD_Q,
		ST_SQ_P,
		ST_SQ_Q,
		ST_MARK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_T_START,
		ST_T_RD,
		ST_T_LOAD,
		ST_T_SQ,
		ST_T_DIV,
		ST_T_REM,
		ST_DONE
	} spt_state_t;

endpackage

`default_nettype wire

>>> rtl/sieve_prime_table_primality_test_top.sv
// ----------------------------------------------------------------------------
// sieve_prime_table_primality_test_top
// builds a prime table with a sieve and tests numbers by trial division
// ----------------------------------------------------------------------------
// usage
//   input beat: func 0 builds the table below sieve_limit, func 1 tests number
//   output beat: one per input beat with is_prime, list_short, prime_count
//   both channels use valid/stall; in_stall is high from an accepted input
//   beat until its result is moved into the output register
//   build: clears the bitmap below the limit, seeds the table with 2 and 3,
//   then per sieving prime p marks multiples of p from p*p and scans the
//   candidates up to the next prime's square, adding unmarked ones
//   test: per prime, a square check then the one-bit-a-cycle remainder unit
//   sieve_limit is written over the apb port; the user writes it only while
//   idle, which the block does not enforce; reset value 65536
//   reset empties the table (count zero); memory contents are not cleared
//   a stalled output beat holds; the next input beat is still taken, and its
//   result waits in the sequencer until the output register frees
// ----------------------------------------------------------------------------
`default_nettype none

module sieve_prime_table_primality_test_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire spt_pkg::spt_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output spt_pkg::spt_out_t      out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import spt_pkg::*;

	spt_state_t state_q, state_d;

	logic [LIMIT_W-1:0] sieve_limit_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] limit_eff;
	logic [LIMIT_W-1:0] clr_q;
	logic [COUNT_W-1:0] held_q;
	logic [COUNT_W-1:0] i_q;
	logic [NUM_W-1:0]   n_q;
	logic [PRIME_W-1:0] p_q;
	logic [PRIME_W-1:0] q_q;
	logic [31:0]        pp_q;
	logic [31:0]        j_q;
	logic [31:0]        k_q;
	logic [LIMIT_W-1:0] stop_q;
	logic [PRIME_W:0]   rem_q;
	logic [PRIME_W:0]   rem_sh;
	logic [NUM_W-1:0]   nsh_q;
	logic [4:0]         cnt_q;
	logic               prime_q;
	logic               short_q;
	logic               out_valid_q;
	spt_out_t           out_q;

	logic [PRIME_W-1:0] mul_a, mul_b;
	logic [31:0]        mul_q;

	logic               map_mem [0:SIEVE_SIZE-1];
	logic               map_we, map_wd, map_rd;
	logic [MAP_AW-1:0]  map_wa, map_ra;
	logic [PRIME_W-1:0] tbl_mem [0:PRIME_DEPTH-1];
	logic               tbl_we;
	logic [TBL_AW-1:0]  tbl_wa, tbl_ra;
	logic [PRIME_W-1:0] tbl_wd, tbl_rd;

	logic in_acc, cfg_wr, round_go, out_load;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == ADDR_SIEVE_LIMIT[2]);
	assign prdata    = (paddr[2] == ADDR_SIEVE_LIMIT[2]) ? {15'd0, sieve_limit_q} : 32'd0;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign limit_eff = (sieve_limit_q > LIMIT_W'(SIEVE_SIZE)) ? LIMIT_W'(SIEVE_SIZE)
		: sieve_limit_q;
	assign rem_sh    = {rem_q[PRIME_W-1:0], nsh_q[NUM_W-1]};
	assign round_go  = (i_q < COUNT_W'(ROUND_MAX)) && (mul_q <= {15'd0, limit_q})
		&& (({1'b0, i_q} + 15'd1) < {1'b0, held_q});

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd <= map_mem[map_ra];
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		tbl_rd <= tbl_mem[tbl_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sieve_limit_q <= LIMIT_W'(SIEVE_SIZE);
			held_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				sieve_limit_q <= pwdata[LIMIT_W-1:0];
			end
			if (state_q == ST_SEED1) begin
				held_q <= COUNT_W'(2);
			end else if (tbl_we && state_q == ST_SCAN_CHK) begin
				held_q <= held_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q     <= in_data.number;
				limit_q <= limit_eff;
				clr_q   <= '0;
				i_q     <= '0;
				prime_q <= 1'b0;
				short_q <= 1'b0;
			end
			ST_CLEAR: clr_q <= clr_q + 1'b1;
			ST_LOAD_P: p_q <= tbl_rd;
			ST_LOAD_Q: q_q <= tbl_rd;
			ST_SQ_P: begin
				pp_q <= mul_q;
				j_q  <= mul_q;
			end
			ST_SQ_Q: stop_q <= (mul_q > {15'd0, limit_q}) ? limit_q : mul_q[LIMIT_W-1:0];
			ST_MARK: begin
				if (j_q < {15'd0, limit_q}) begin
					j_q <= j_q + {16'd0, p_q};
				end else begin
					k_q <= pp_q + 32'd1;
				end
			end
			ST_SCAN_RD: begin
				if (k_q >= {15'd0, stop_q}) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_SCAN_CHK: k_q <= k_q + 32'd1;
			ST_T_START: i_q <= '0;
			ST_T_RD: begin
				if (i_q >= held_q) begin
					short_q <= 1'b1;
				end
			end
			ST_T_LOAD: begin
				p_q <= tbl_rd;
				if (tbl_rd == '0) begin
					short_q <= 1'b1;
				end
			end
			ST_T_SQ: begin
				if (mul_q > n_q) begin
					prime_q <= 1'b1;
				end
				rem_q <= '0;
				cnt_q <= 5'd31;
				nsh_q <= n_q;
			end
			ST_T_DIV: begin
				rem_q <= (rem_sh >= {1'b0, p_q}) ? rem_sh - {1'b0, p_q} : rem_sh;
				nsh_q <= {nsh_q[NUM_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_T_REM: begin
				if (rem_q != '0) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_q.is_prime    <= prime_q;
					out_q.list_short  <= short_q;
					out_q.prime_count <= held_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		map_we  = 1'b0;
		map_wa  = j_q[MAP_AW-1:0];
		map_wd  = 1'b1;
		map_ra  = k_q[MAP_AW-1:0];
		tbl_we  = 1'b0;
		tbl_wa  = held_q[TBL_AW-1:0];
		tbl_wd  = k_q[PRIME_W-1:0];
		tbl_ra  = i_q[TBL_AW-1:0];
		mul_a   = p_q;
		mul_b   = p_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (in_data.func == FUNC_BUILD) ? ST_CLEAR : ST_T_START;
				end
			end
			ST_CLEAR: begin
				map_wa = clr_q[MAP_AW-1:0];
				map_wd = (clr_q <= LIMIT_W'(1));
				if (clr_q < limit_q) begin
					map_we = 1'b1;
				end else begin
					state_d = ST_SEED0;
				end
			end
			ST_SEED0: begin
				tbl_we  = 1'b1;
				tbl_wa  = TBL_AW'(0);
				tbl_wd  = PRIME_W'(2);
				state_d = ST_SEED1;
			end
			ST_SEED1: begin
				tbl_we  = 1'b1;
				tbl_wa  = TBL_AW'(1);
				tbl_wd  = PRIME_W'(3);
				state_d = ST_ROUND_MUL;
			end
			ST_ROUND_MUL: begin
				mul_a   = {7'd0, i_q[8:0]} + 16'd1;
				mul_b   = {7'd0, i_q[8:0]} + 16'd1;
				state_d = ST_ROUND_CHK;
			end
			ST_ROUND_CHK: state_d = round_go ? ST_LOAD_P : ST_DONE;
			ST_LOAD_P: begin
				tbl_ra  = i_q[TBL_AW-1:0] + 1'b1;
				state_d = ST_LOAD_Q;
			end
			ST_LOAD_Q: state_d = ST_SQ_P;
			ST_SQ_P: begin
				mul_a   = q_q;
				mul_b   = q_q;
				state_d = ST_SQ_Q;
			end
			ST_SQ_Q: state_d = ST_MARK;
			ST_MARK: begin
				if (j_q < {15'd0, limit_q}) begin
					map_we = 1'b1;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: state_d = (k_q < {15'd0, stop_q}) ? ST_SCAN_CHK : ST_ROUND_MUL;
			ST_SCAN_CHK: begin
				tbl_we  = !map_rd && (held_q < COUNT_W'(PRIME_DEPTH));
				state_d = ST_SCAN_RD;
			end
			ST_T_START: state_d = (n_q <= NUM_W'(1)) ? ST_DONE : ST_T_RD;
			ST_T_RD: state_d = (i_q < held_q) ? ST_T_LOAD : ST_DONE;
			ST_T_LOAD: begin
				mul_a   = tbl_rd;
				mul_b   = tbl_rd;
				state_d = (tbl_rd == '0) ? ST_DONE : ST_T_SQ;
			end
			ST_T_SQ: state_d = (mul_q > n_q) ? ST_DONE : ST_T_DIV;
			ST_T_DIV: state_d = (cnt_q == '0) ? ST_T_REM : ST_T_DIV;
			ST_T_REM: state_d = (rem_q == '0) ? ST_DONE : ST_T_RD;
			ST_DONE: state_d = out_load ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/spt_checker.sv
// ----------------------------------------------------------------------------
// spt_checker
// port level checks of the sieve prime table block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spt_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire spt_pkg::spt_out_t out_data
);
	import spt_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_SAME(a_excl, clk, arst_n, out_valid, !(out_data.is_prime && out_data.list_short))
	`ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`ASSERT_SAME(a_count, clk, arst_n, out_valid && out_data.is_prime, out_data.prime_count != '0)

endmodule

bind sieve_prime_table_primality_test_top spt_checker u_spt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
